// ===== sv/upmb_pkg.sv =====
`default_nettype none
package upmb_pkg;

	localparam int NUM_CH = 3;

	localparam logic [7:0] FULL = 8'd255;
	localparam logic [7:0] MIN_DIV_ALPHA = 8'd3;

	// The reciprocal of 510 scaled by 2^26, rounded up, is exact for every mask numerator.
	localparam logic [17:0] MASK_RECIP = 18'd131587;
	localparam int MASK_SHIFT = 26;

	// The reciprocal of 255 scaled by 2^24, rounded up, is exact for every blend numerator.
	localparam logic [16:0] BLEND_RECIP = 17'd65794;
	localparam int BLEND_SHIFT = 24;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] marker;
		logic [7:0] color_c0;
		logic [7:0] color_c1;
		logic [7:0] color_c2;
		logic [7:0] paper_c0;
		logic [7:0] paper_c1;
		logic [7:0] paper_c2;
	} upmb_pixel_t;

	typedef struct packed {
		logic [7:0] out_c0;
		logic [7:0] out_c1;
		logic [7:0] out_c2;
	} upmb_result_t;

	typedef struct packed {
		logic [7:0] alpha_s1;
		logic [7:0] alpha_s2;
		logic       low_s2;
		logic [7:0] k_s3;
	} upmb_ctl_t;

endpackage
`default_nettype wire

// ===== sv/upmb_mask.sv =====
`default_nettype none
module upmb_mask (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [7:0]        alpha,
	input  wire logic [7:0]        marker,
	output upmb_pkg::upmb_ctl_t    ctl
);

	logic [7:0]  alpha_s1;
	logic        low_s1;
	logic [15:0] prod_s1;
	logic [7:0]  alpha_s2;
	logic        low_s2;
	logic [7:0]  k_s2;
	logic [7:0]  k_s3;
	logic [16:0] num;
	logic [34:0] scaled;

	assign num = {prod_s1, 1'b0} + 17'(upmb_pkg::FULL);
	assign scaled = 35'(num) * 35'(upmb_pkg::MASK_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s1 <= alpha;
			low_s1 <= alpha < upmb_pkg::MIN_DIV_ALPHA;
			prod_s1 <= 16'(alpha) * 16'(marker);
			alpha_s2 <= alpha_s1;
			low_s2 <= low_s1;
			k_s2 <= scaled[upmb_pkg::MASK_SHIFT + 7:upmb_pkg::MASK_SHIFT];
			k_s3 <= k_s2;
		end
	end

	assign ctl.alpha_s1 = alpha_s1;
	assign ctl.alpha_s2 = alpha_s2;
	assign ctl.low_s2 = low_s2;
	assign ctl.k_s3 = k_s3;

endmodule
`default_nettype wire

// ===== sv/upmb_lane.sv =====
`default_nettype none
module upmb_lane (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [7:0]          color,
	input  wire logic [7:0]          paper,
	input  wire upmb_pkg::upmb_ctl_t ctl,
	output logic [7:0]               chan
);

	logic [15:0] n_s1;
	logic [7:0]  color_s1;
	logic [7:0]  paper_s1;
	logic [15:0] rem_s2;
	logic [3:0]  qh_s2;
	logic        sat_s2;
	logic [7:0]  color_s2;
	logic [7:0]  paper_s2;
	logic [7:0]  u_s3;
	logic [7:0]  paper_s3;
	logic [15:0] num_s4;
	logic [7:0]  out_s5;

	logic [15:0] rem_hi;
	logic [3:0]  q_hi;
	logic [15:0] rem_lo;
	logic [3:0]  q_lo;
	logic [15:0] mix_p;
	logic [15:0] mix_u;
	logic [16:0] mix_sum;
	logic [32:0] scaled;

	// Restoring division, upper four quotient bits.
	always_comb begin
		logic [15:0] dsr;
		rem_hi = n_s1;
		q_hi = '0;
		for (int i = 3; i >= 0; i--) begin
			dsr = 16'({8'h00, ctl.alpha_s1} << (i + 4));
			if (rem_hi >= dsr) begin
				rem_hi = rem_hi - dsr;
				q_hi[i] = 1'b1;
			end
		end
	end

	// Restoring division, lower four quotient bits.
	always_comb begin
		logic [15:0] dsr;
		rem_lo = rem_s2;
		q_lo = '0;
		for (int i = 3; i >= 0; i--) begin
			dsr = 16'({8'h00, ctl.alpha_s2} << i);
			if (rem_lo >= dsr) begin
				rem_lo = rem_lo - dsr;
				q_lo[i] = 1'b1;
			end
		end
	end

	assign mix_p = 16'(paper_s3) * 16'(8'(upmb_pkg::FULL - ctl.k_s3));
	assign mix_u = 16'(u_s3) * 16'(ctl.k_s3);
	assign mix_sum = 17'(mix_p) + 17'(mix_u);
	assign scaled = 33'(num_s4) * 33'(upmb_pkg::BLEND_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= {color, 8'h00} - {8'h00, color};
			color_s1 <= color;
			paper_s1 <= paper;

			rem_s2 <= rem_hi;
			qh_s2 <= q_hi;
			sat_s2 <= n_s1 >= {ctl.alpha_s1, 8'h00};
			color_s2 <= color_s1;
			paper_s2 <= paper_s1;

			if (ctl.low_s2) begin
				u_s3 <= color_s2;
			end else if (sat_s2) begin
				u_s3 <= upmb_pkg::FULL;
			end else begin
				u_s3 <= {qh_s2, q_lo};
			end
			paper_s3 <= paper_s2;

			num_s4 <= mix_sum[15:0];

			out_s5 <= scaled[upmb_pkg::BLEND_SHIFT + 7:upmb_pkg::BLEND_SHIFT];
		end
	end

	assign chan = out_s5;

endmodule
`default_nettype wire

// ===== sv/unpremultiply_mask_and_blend_pixel_unit.sv =====
// An accepted pixel word passes through stages s1 to s5 to become its result word.
// Throughput: one pixel word per cycle unless stalled; each color channel has
// its own lane; the division spans two stages of four quotient bits each.
// A one-word skid register on the input keeps pixel_stall registered.
// Reset (arst_n low, asynchronous) empties the pipeline and the skid register.
`default_nettype none
module unpremultiply_mask_and_blend_pixel_unit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   pixel_valid,
	output logic                        pixel_stall,
	input  wire upmb_pkg::upmb_pixel_t  pixel,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output upmb_pkg::upmb_result_t      result
);

	upmb_pkg::upmb_pixel_t skid_q;
	logic                  skid_valid_q;
	upmb_pkg::upmb_pixel_t src;
	logic                  src_valid;
	logic                  en;
	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic                  v_s4;
	logic                  v_s5;
	upmb_pkg::upmb_ctl_t   ctl;
	logic [7:0]            color_ch [upmb_pkg::NUM_CH];
	logic [7:0]            paper_ch [upmb_pkg::NUM_CH];
	logic [7:0]            out_ch [upmb_pkg::NUM_CH];

	assign en = !(v_s5 && result_stall);
	assign src = skid_valid_q ? skid_q : pixel;
	assign src_valid = skid_valid_q || pixel_valid;
	assign pixel_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end else if (pixel_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && pixel_valid && !skid_valid_q) begin
			skid_q <= pixel;
		end
	end

	assign color_ch[0] = src.color_c0;
	assign color_ch[1] = src.color_c1;
	assign color_ch[2] = src.color_c2;
	assign paper_ch[0] = src.paper_c0;
	assign paper_ch[1] = src.paper_c1;
	assign paper_ch[2] = src.paper_c2;

	upmb_mask u_mask (
		.clk    (clk),
		.en     (en),
		.alpha  (src.alpha),
		.marker (src.marker),
		.ctl    (ctl)
	);

	for (genvar ch = 0; ch < upmb_pkg::NUM_CH; ch++) begin : g_lane
		upmb_lane u_lane (
			.clk   (clk),
			.en    (en),
			.color (color_ch[ch]),
			.paper (paper_ch[ch]),
			.ctl   (ctl),
			.chan  (out_ch[ch])
		);
	end

	assign result_valid = v_s5;
	assign result.out_c0 = out_ch[0];
	assign result.out_c1 = out_ch[1];
	assign result.out_c2 = out_ch[2];

`ifndef NO_ASSERTIONS
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(v_s5 && result_stall))
		else $error("skid register filled while the pipeline was moving");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(skid_valid_q) |-> $past(en) && v_s1)
		else $error("skid register drained without entering the pipeline");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s4 |=> v_s5)
		else $error("word lost between the last two pipeline stages");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4}))
		else $error("pipeline moved while the output was stalled");
`endif

endmodule
`default_nettype wire
